/* hw/rtl/ssl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substitution score lookup package
// Command and register codes, folding constants and the control structures
// shared by the lookup unit and its submodules.
// ----------------------------------------------------------------------------
package ssl_pkg;

    // Commands carried by the request channel.
    typedef enum logic [1:0] {
        CMD_LOOKUP     = 2'd0,
        CMD_WRITE_PAIR = 2'd1,
        CMD_WRITE_WILD = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_command;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MATCH_SCORE    = 3'd0,
        CFG_MISMATCH_SCORE = 3'd1,
        CFG_GAP_OPEN       = 3'd2,
        CFG_GAP_EXTEND     = 3'd3,
        CFG_GAPS_ALLOWED   = 3'd4,
        CFG_NO_MISMATCH    = 3'd5,
        CFG_CASE_SENSITIVE = 3'd6,
        CFG_USE_FALLBACK   = 3'd7
    } t_cfg_index;

    // ASCII case folding works on a copy one bit wider than a byte.
    localparam int FOLD_BITS = 9;
    localparam logic [FOLD_BITS-1:0] ASCII_UPPER_A     = 9'd65;
    localparam logic [FOLD_BITS-1:0] ASCII_UPPER_Z     = 9'd90;
    localparam logic [FOLD_BITS-1:0] ASCII_CASE_OFFSET = 9'd32;

    // Single-bit configuration flags.
    typedef struct packed {
        logic gaps_allowed;
        logic no_mismatch_mode;
        logic keep_case;
        logic use_fallback;
    } t_cfg_flags;

    // Control carried alongside the memory reads into the resolve stage.
    typedef struct packed {
        t_command command;
        logic     chars_equal;
    } t_lookup_ctl;

endpackage

/* hw/rtl/ssl_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substitution score lookup channels
// Valid/ready interfaces for the request, response and configuration words.
// ----------------------------------------------------------------------------

// Request channel: one command word per handshake.
interface ssl_req_if #(
    parameter int CHAR_BITS  = 7,
    parameter int SCORE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [CHAR_BITS-1:0]         char_a;
    logic [CHAR_BITS-1:0]         char_b;
    logic signed [SCORE_BITS-1:0] score_value;

    modport source (output valid, command, char_a, char_b, score_value, input ready);
    modport sink   (input valid, command, char_a, char_b, score_value, output ready);
endinterface

// Response channel: one result word per command.
interface ssl_rsp_if #(
    parameter int SCORE_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [SCORE_BITS-1:0] pair_score;
    logic                       match_flag;
    logic                       unknown_pair;
    logic signed [SCORE_BITS:0] pen_floor;
    logic signed [SCORE_BITS:0] pen_ceil;

    modport source (output valid, pair_score, match_flag, unknown_pair, pen_floor,
                    pen_ceil, input ready);
    modport sink   (input valid, pair_score, match_flag, unknown_pair, pen_floor,
                    pen_ceil, output ready);
endinterface

// Configuration write channel.
interface ssl_cfg_if #(
    parameter int SCORE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            reg_index;
    logic [SCORE_BITS-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* hw/rtl/ssl_pair_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair score store
// Synchronous memory of {valid, score} entries indexed by the character pair,
// with a sweep that clears every valid bit after reset and on a clear command.
// ----------------------------------------------------------------------------
module ssl_pair_store #(
    parameter int ADDR_BITS  = 14,
    parameter int SCORE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear_start,
    input  logic                         i_wr_en,
    input  logic [ADDR_BITS-1:0]         i_wr_addr,
    input  logic signed [SCORE_BITS-1:0] i_wr_score,
    input  logic                         i_rd_en,
    input  logic [ADDR_BITS-1:0]         i_rd_addr,
    output logic                         o_busy,
    output logic                         o_rd_valid,
    output logic signed [SCORE_BITS-1:0] o_rd_score
);
    import ssl_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [SCORE_BITS:0]   r_mem [DEPTH];
    logic [SCORE_BITS:0]   r_rd_data;
    logic                  r_busy;
    logic [ADDR_BITS-1:0]  r_sweep_addr;

    // Clearing sweep: one entry per cycle, started by reset or a clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_busy) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            if (&r_sweep_addr) begin
                r_busy <= 1'b0;
            end
        end else if (i_clear_start) begin
            r_busy       <= 1'b1;
            r_sweep_addr <= '0;
        end
    end

    // Memory port: the sweep owns the write side while it runs.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_sweep_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= {1'b1, i_wr_score};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy     = r_busy;
    assign o_rd_valid = r_rd_data[SCORE_BITS];
    assign o_rd_score = $signed(r_rd_data[SCORE_BITS-1:0]);

endmodule

/* hw/rtl/ssl_wild_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard score store
// Per-character wildcard scores in a memory with two registered read ports,
// and a valid bit per character held in flip-flops.
// ----------------------------------------------------------------------------
module ssl_wild_store #(
    parameter int CHAR_BITS  = 7,
    parameter int SCORE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_wr_en,
    input  logic [CHAR_BITS-1:0]         i_wr_addr,
    input  logic signed [SCORE_BITS-1:0] i_wr_score,
    input  logic                         i_rd_en,
    input  logic [CHAR_BITS-1:0]         i_rd_addr_a,
    input  logic [CHAR_BITS-1:0]         i_rd_addr_b,
    output logic                         o_valid_a,
    output logic signed [SCORE_BITS-1:0] o_score_a,
    output logic                         o_valid_b,
    output logic signed [SCORE_BITS-1:0] o_score_b
);
    import ssl_pkg::*;

    localparam int DEPTH = 1 << CHAR_BITS;

    logic signed [SCORE_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_valid;
    logic                         r_valid_a;
    logic                         r_valid_b;
    logic signed [SCORE_BITS-1:0] r_score_a;
    logic signed [SCORE_BITS-1:0] r_score_b;

    // Valid bits clear all at once on reset or a clear command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Score memory with one write and two registered reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_score;
        end
        if (i_rd_en) begin
            r_score_a <= r_mem[i_rd_addr_a];
            r_score_b <= r_mem[i_rd_addr_b];
            r_valid_a <= r_valid[i_rd_addr_a];
            r_valid_b <= r_valid[i_rd_addr_b];
        end
    end

    assign o_valid_a = r_valid_a;
    assign o_valid_b = r_valid_b;
    assign o_score_a = r_score_a;
    assign o_score_b = r_score_b;

endmodule

/* hw/rtl/ssl_resolve.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Score resolve stage
// Picks the final score and flags of a lookup from the pair entry, the
// wildcard entries and the match/mismatch fallback.
// ----------------------------------------------------------------------------
module ssl_resolve #(
    parameter int SCORE_BITS = 16
) (
    input  ssl_pkg::t_lookup_ctl         i_ctl,
    input  ssl_pkg::t_cfg_flags          i_flags,
    input  logic signed [SCORE_BITS-1:0] i_match_score,
    input  logic signed [SCORE_BITS-1:0] i_mismatch_score,
    input  logic                         i_pair_valid,
    input  logic signed [SCORE_BITS-1:0] i_pair_score,
    input  logic                         i_wild_a_valid,
    input  logic signed [SCORE_BITS-1:0] i_wild_a_score,
    input  logic                         i_wild_b_valid,
    input  logic signed [SCORE_BITS-1:0] i_wild_b_score,
    output logic signed [SCORE_BITS-1:0] o_score,
    output logic                         o_match,
    output logic                         o_unknown
);
    import ssl_pkg::*;

    logic                         wild_found;
    logic signed [SCORE_BITS-1:0] wild_score;

    // With both wildcards present the smaller score wins.
    always_comb begin
        wild_found = i_wild_a_valid | i_wild_b_valid;
        if (i_wild_a_valid && i_wild_b_valid) begin
            wild_score = (i_wild_b_score < i_wild_a_score) ? i_wild_b_score : i_wild_a_score;
        end else if (i_wild_a_valid) begin
            wild_score = i_wild_a_score;
        end else begin
            wild_score = i_wild_b_score;
        end
    end

    // Priority: no-mismatch mode, pair entry, wildcard, fallback, unknown.
    always_comb begin
        o_score   = '0;
        o_match   = 1'b0;
        o_unknown = 1'b0;
        if (i_ctl.command == CMD_LOOKUP) begin
            if (i_flags.no_mismatch_mode && !i_ctl.chars_equal) begin
                o_match = wild_found;
                o_score = wild_found ? wild_score : '0;
            end else if (i_pair_valid) begin
                o_match = i_ctl.chars_equal;
                o_score = i_pair_score;
            end else if (wild_found) begin
                o_match = 1'b1;
                o_score = wild_score;
            end else if (i_flags.use_fallback) begin
                o_match = i_ctl.chars_equal;
                o_score = i_ctl.chars_equal ? i_match_score : i_mismatch_score;
            end else begin
                o_unknown = 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/substitution_score_lookup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substitution score lookup unit
// Pair and wildcard score tables for an alignment kernel, with running
// minimum and maximum penalty tracking.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command word: lookup, write pair, write wildcard or
//   clear. Every accepted word returns exactly one result word on o_rsp.
//   i_cfg writes the scoring registers; it is always ready and is meant to be
//   used while no command is in flight.
// Timing:
//   A command reads the memories on the edge that accepts it and its result
//   is registered from the read stage once the result register is free.
//   One command per cycle is taken back to back while o_rsp.ready is high.
//   A clear blocks i_req while the pair memory's valid bits are swept one
//   entry per cycle; the same sweep runs right after reset before the first
//   command is taken.
// Stall:
//   The result register holds while o_rsp.ready is low; one more command can
//   wait in the memory read stage, after which i_req.ready drops.
// ----------------------------------------------------------------------------
module substitution_score_lookup_unit #(
    parameter int CHAR_BITS  = 7,
    parameter int SCORE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssl_req_if.sink   i_req,
    ssl_rsp_if.source o_rsp,
    ssl_cfg_if.sink   i_cfg
);
    import ssl_pkg::*;

    localparam int ADDR_BITS = 2 * CHAR_BITS;
    localparam int WIDE_BITS = SCORE_BITS + 1;

    localparam logic signed [WIDE_BITS-1:0]  RUN_MIN_RESET       = WIDE_BITS'(-5);
    localparam logic signed [WIDE_BITS-1:0]  RUN_MAX_RESET       = WIDE_BITS'(1);
    localparam logic signed [SCORE_BITS-1:0] MATCH_SCORE_RESET   = SCORE_BITS'(1);
    localparam logic signed [SCORE_BITS-1:0] MISMATCH_RESET      = SCORE_BITS'(-2);
    localparam logic signed [SCORE_BITS-1:0] GAP_OPEN_RESET      = SCORE_BITS'(-4);
    localparam logic signed [SCORE_BITS-1:0] GAP_EXTEND_RESET    = SCORE_BITS'(-1);

    function automatic logic [CHAR_BITS-1:0] fold_char(input logic [CHAR_BITS-1:0] c,
                                                       input logic case_sens);
        logic [FOLD_BITS-1:0] wide;
        wide = FOLD_BITS'(c);
        if (!case_sens && wide >= ASCII_UPPER_A && wide <= ASCII_UPPER_Z) begin
            wide = wide + ASCII_CASE_OFFSET;
        end
        return wide[CHAR_BITS-1:0];
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] smin(input logic signed [WIDE_BITS-1:0] x,
                                                         input logic signed [WIDE_BITS-1:0] y);
        return (y < x) ? y : x;
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] smax(input logic signed [WIDE_BITS-1:0] x,
                                                         input logic signed [WIDE_BITS-1:0] y);
        return (y > x) ? y : x;
    endfunction

    // Configuration registers.
    logic signed [SCORE_BITS-1:0] r_match_score;
    logic signed [SCORE_BITS-1:0] r_mismatch_score;
    logic signed [SCORE_BITS-1:0] r_gap_open;
    logic signed [SCORE_BITS-1:0] r_gap_extend;
    t_cfg_flags                   r_flags;

    // Running penalty range.
    logic signed [WIDE_BITS-1:0]  r_run_min;
    logic signed [WIDE_BITS-1:0]  r_run_max;
    logic signed [WIDE_BITS-1:0]  n_run_min;
    logic signed [WIDE_BITS-1:0]  n_run_max;

    // Request decode.
    t_command                     cmd;
    logic                         accept;
    logic                         pair_busy;
    logic [CHAR_BITS-1:0]         a_fold;
    logic [CHAR_BITS-1:0]         b_fold;
    logic                         is_lookup;
    logic                         is_clear;

    // Read stage and result register.
    logic                         r_s1_valid;
    t_lookup_ctl                  r_s1_ctl;
    logic                         s1_adv;
    logic                         r_out_valid;
    logic signed [SCORE_BITS-1:0] r_out_score;
    logic                         r_out_match;
    logic                         r_out_unknown;
    logic signed [WIDE_BITS-1:0]  r_out_min;
    logic signed [WIDE_BITS-1:0]  r_out_max;

    // Memory and resolve outputs.
    logic                         pair_valid;
    logic signed [SCORE_BITS-1:0] pair_score;
    logic                         wild_a_valid;
    logic signed [SCORE_BITS-1:0] wild_a_score;
    logic                         wild_b_valid;
    logic signed [SCORE_BITS-1:0] wild_b_score;
    logic signed [SCORE_BITS-1:0] res_score;
    logic                         res_match;
    logic                         res_unknown;

    // Clear-time range terms.
    logic signed [WIDE_BITS-1:0]  match_w;
    logic signed [WIDE_BITS-1:0]  mismatch_w;
    logic signed [WIDE_BITS-1:0]  gap_ext_w;
    logic signed [WIDE_BITS-1:0]  gap_sum_w;
    logic signed [WIDE_BITS-1:0]  value_w;

    // Configuration writes; the port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_score          <= MATCH_SCORE_RESET;
            r_mismatch_score       <= MISMATCH_RESET;
            r_gap_open             <= GAP_OPEN_RESET;
            r_gap_extend           <= GAP_EXTEND_RESET;
            r_flags.gaps_allowed     <= 1'b1;
            r_flags.no_mismatch_mode <= 1'b0;
            r_flags.keep_case        <= 1'b0;
            r_flags.use_fallback     <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_index'(i_cfg.reg_index))
                CFG_MATCH_SCORE:    r_match_score            <= $signed(i_cfg.wr_data);
                CFG_MISMATCH_SCORE: r_mismatch_score         <= $signed(i_cfg.wr_data);
                CFG_GAP_OPEN:       r_gap_open               <= $signed(i_cfg.wr_data);
                CFG_GAP_EXTEND:     r_gap_extend             <= $signed(i_cfg.wr_data);
                CFG_GAPS_ALLOWED:   r_flags.gaps_allowed     <= i_cfg.wr_data[0];
                CFG_NO_MISMATCH:    r_flags.no_mismatch_mode <= i_cfg.wr_data[0];
                CFG_CASE_SENSITIVE: r_flags.keep_case        <= i_cfg.wr_data[0];
                CFG_USE_FALLBACK:   r_flags.use_fallback     <= i_cfg.wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Request decode and handshake.
    assign cmd       = t_command'(i_req.command);
    assign a_fold    = fold_char(i_req.char_a, r_flags.keep_case);
    assign b_fold    = fold_char(i_req.char_b, r_flags.keep_case);
    assign s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !pair_busy && (!r_s1_valid || s1_adv);
    assign accept    = i_req.valid && i_req.ready;
    assign is_lookup = accept && (cmd == CMD_LOOKUP);
    assign is_clear  = accept && (cmd == CMD_CLEAR);

    ssl_pair_store #(
        .ADDR_BITS  (ADDR_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_pair_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear_start (is_clear),
        .i_wr_en       (accept && (cmd == CMD_WRITE_PAIR)),
        .i_wr_addr     ({i_req.char_a, i_req.char_b}),
        .i_wr_score    (i_req.score_value),
        .i_rd_en       (is_lookup),
        .i_rd_addr     ({a_fold, b_fold}),
        .o_busy        (pair_busy),
        .o_rd_valid    (pair_valid),
        .o_rd_score    (pair_score)
    );

    ssl_wild_store #(
        .CHAR_BITS  (CHAR_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_wild_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (is_clear),
        .i_wr_en     (accept && (cmd == CMD_WRITE_WILD)),
        .i_wr_addr   (a_fold),
        .i_wr_score  (i_req.score_value),
        .i_rd_en     (is_lookup),
        .i_rd_addr_a (a_fold),
        .i_rd_addr_b (b_fold),
        .o_valid_a   (wild_a_valid),
        .o_score_a   (wild_a_score),
        .o_valid_b   (wild_b_valid),
        .o_score_b   (wild_b_score)
    );

    // Running range: a clear rebuilds it from the registers, writes widen it.
    assign match_w    = WIDE_BITS'(r_match_score);
    assign mismatch_w = WIDE_BITS'(r_mismatch_score);
    assign gap_ext_w  = WIDE_BITS'(r_gap_extend);
    assign gap_sum_w  = WIDE_BITS'(r_gap_open) + gap_ext_w;
    assign value_w    = WIDE_BITS'(i_req.score_value);

    always_comb begin
        n_run_min = r_run_min;
        n_run_max = r_run_max;
        if (accept) begin
            case (cmd)
                CMD_CLEAR: begin
                    n_run_min = smin(match_w, mismatch_w);
                    n_run_max = smax(match_w, mismatch_w);
                    if (r_flags.gaps_allowed) begin
                        n_run_min = smin(n_run_min, smin(gap_sum_w, gap_ext_w));
                        n_run_max = smax(n_run_max, smax(gap_sum_w, gap_ext_w));
                    end
                end
                CMD_WRITE_PAIR, CMD_WRITE_WILD: begin
                    n_run_min = smin(r_run_min, value_w);
                    n_run_max = smax(r_run_max, value_w);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min <= RUN_MIN_RESET;
            r_run_max <= RUN_MAX_RESET;
        end else begin
            r_run_min <= n_run_min;
            r_run_max <= n_run_max;
        end
    end

    // Read stage: holds the command whose memory data is on the read ports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_ctl.command     <= cmd;
            r_s1_ctl.chars_equal <= (a_fold == b_fold);
        end
    end

    ssl_resolve #(
        .SCORE_BITS (SCORE_BITS)
    ) u_resolve (
        .i_ctl            (r_s1_ctl),
        .i_flags          (r_flags),
        .i_match_score    (r_match_score),
        .i_mismatch_score (r_mismatch_score),
        .i_pair_valid     (pair_valid),
        .i_pair_score     (pair_score),
        .i_wild_a_valid   (wild_a_valid),
        .i_wild_a_score   (wild_a_score),
        .i_wild_b_valid   (wild_b_valid),
        .i_wild_b_score   (wild_b_score),
        .o_score          (res_score),
        .o_match          (res_match),
        .o_unknown        (res_unknown)
    );

    // Result register; the range is sampled while no later command has landed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_out_score   <= res_score;
            r_out_match   <= res_match;
            r_out_unknown <= res_unknown;
            r_out_min     <= r_run_min;
            r_out_max     <= r_run_max;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.pair_score   = r_out_score;
    assign o_rsp.match_flag   = r_out_match;
    assign o_rsp.unknown_pair = r_out_unknown;
    assign o_rsp.pen_floor    = r_out_min;
    assign o_rsp.pen_ceil     = r_out_max;

    // Checks on the control and the running range.
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_clear |=> pair_busy)
        else $error("clear accepted without starting the valid sweep");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair_busy |-> !i_req.ready)
        else $error("request ready while the pair memory is being cleared");

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_min <= r_run_max)
        else $error("running minimum above running maximum");

    a_unknown_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_unknown) |-> (!r_out_match && (r_out_score == '0)))
        else $error("unknown pair reported with a score or a match");

endmodule
